FILE: hw/rtl/sfr_pkg.sv
// ============================================================================
// sfr_pkg - shared types and constants for the servo frame receiver
// Frame layout, phase and status codes, register indexes and the
// structs passed between the receiver's modules.
// ============================================================================
package sfr_pkg;

    localparam int BYTE_W      = 8;
    localparam int WORD_W      = 16;
    localparam int BODY_KEPT   = 6;  // frame bytes 2..7 kept
    localparam int LAST_BODY   = 7;  // body count value at the tail byte
    localparam int COUNT_W     = 4;
    localparam int STORE_IDX_W = $clog2(BODY_KEPT);
    localparam int CFG_IDX_W   = 2;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [WORD_W-1:0] word_t;

    typedef enum logic [1:0] {
        PH_HUNT   = 2'd0,
        PH_SECOND = 2'd1,
        PH_BODY   = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        ST_GOOD     = 2'd0,
        ST_TAIL_BAD = 2'd1,
        ST_SUM_BAD  = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HEADER_FIRST  = 2'd0,
        REG_HEADER_SECOND = 2'd1,
        REG_TAIL_BYTE     = 2'd2
    } cfg_idx_t;

    localparam byte_t HEADER_FIRST_RST  = 8'hFA;
    localparam byte_t HEADER_SECOND_RST = 8'hAF;
    localparam byte_t TAIL_BYTE_RST     = 8'hED;

    typedef struct packed {
        byte_t header_first;
        byte_t header_second;
        byte_t tail_byte;
    } cfg_t;

    typedef struct packed {
        status_t frame_status;
        byte_t   servo_id;
        byte_t   command;
        word_t   word_first;
        word_t   word_second;
    } result_t;

endpackage

FILE: hw/rtl/sfr_cfg_regs.sv
// ============================================================================
// sfr_cfg_regs - configuration registers
// Header and tail match bytes, written through a valid/ready port.
// ============================================================================
module sfr_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [sfr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sfr_pkg::BYTE_W-1:0]     cfg_data,
    output sfr_pkg::cfg_t                  cfg
);
    import sfr_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_HEADER_FIRST:  cfg_next.header_first  = cfg_data;
                REG_HEADER_SECOND: cfg_next.header_second = cfg_data;
                REG_TAIL_BYTE:     cfg_next.tail_byte     = cfg_data;
                default:           cfg_next = cfg_reg;  // unmapped index
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_first  <= HEADER_FIRST_RST;
            cfg_reg.header_second <= HEADER_SECOND_RST;
            cfg_reg.tail_byte     <= TAIL_BYTE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: hw/rtl/sfr_deframer.sv
// ============================================================================
// sfr_deframer - header hunt, body capture and frame checks
// Updates the framing state for one byte per step and forms the result
// combinationally when the byte is the tail.
// ============================================================================
module sfr_deframer (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       step,
    input  logic [sfr_pkg::BYTE_W-1:0] rx_byte,
    input  sfr_pkg::cfg_t              cfg,
    output logic                       frame_done,
    output sfr_pkg::result_t           result
);
    import sfr_pkg::*;

    phase_t              phase_reg,       phase_next;
    logic [COUNT_W-1:0]  body_count_reg,  body_count_next;
    byte_t               running_sum_reg, running_sum_next;
    byte_t               sum_byte_reg;
    byte_t               body_store_reg [BODY_KEPT];
    logic                store_we;
    logic                sum_byte_we;

    always_comb
    begin
        phase_next       = phase_reg;
        body_count_next  = body_count_reg;
        running_sum_next = running_sum_reg;
        store_we         = 1'b0;
        sum_byte_we      = 1'b0;
        frame_done       = 1'b0;
        unique case (phase_reg)
            PH_SECOND:
            begin
                // second header byte wins when both registers match
                if (rx_byte == cfg.header_second)
                begin
                    phase_next       = PH_BODY;
                    body_count_next  = '0;
                    running_sum_next = '0;
                end
                else if (rx_byte == cfg.header_first)
                begin
                    phase_next = PH_SECOND;
                end
                else
                begin
                    phase_next = PH_HUNT;
                end
            end
            PH_BODY:
            begin
                if (body_count_reg < COUNT_W'(BODY_KEPT))
                begin
                    store_we         = 1'b1;
                    running_sum_next = running_sum_reg + rx_byte;
                    body_count_next  = body_count_reg + 1'b1;
                end
                else if (body_count_reg < COUNT_W'(LAST_BODY))
                begin
                    sum_byte_we     = 1'b1;
                    body_count_next = body_count_reg + 1'b1;
                end
                else
                begin
                    frame_done       = 1'b1;
                    phase_next       = PH_HUNT;
                    body_count_next  = '0;
                    running_sum_next = '0;
                end
            end
            default:
            begin
                phase_next = (rx_byte == cfg.header_first) ? PH_SECOND : PH_HUNT;
            end
        endcase
    end

    // tail is checked before the checksum
    always_comb
    begin
        if (rx_byte != cfg.tail_byte)
            result.frame_status = ST_TAIL_BAD;
        else if (sum_byte_reg != running_sum_reg)
            result.frame_status = ST_SUM_BAD;
        else
            result.frame_status = ST_GOOD;
        result.servo_id    = body_store_reg[0];
        result.command     = body_store_reg[1];
        result.word_first  = {body_store_reg[2], body_store_reg[3]};
        result.word_second = {body_store_reg[4], body_store_reg[5]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_HUNT;
            body_count_reg  <= '0;
            running_sum_reg <= '0;
        end
        else if (step)
        begin
            phase_reg       <= phase_next;
            body_count_reg  <= body_count_next;
            running_sum_reg <= running_sum_next;
        end
    end

    // payload storage, no reset
    always_ff @(posedge clk)
    begin
        if (step && store_we)
            body_store_reg[body_count_reg[STORE_IDX_W-1:0]] <= rx_byte;
        if (step && sum_byte_we)
            sum_byte_reg <= rx_byte;
    end

endmodule

FILE: hw/rtl/servo_frame_receiver_unit.sv
// ============================================================================
// servo_frame_receiver_unit - serial servo frame receiver
// Hunts for a two-byte header, collects a 10-byte frame and reports it.
// ============================================================================
// Feed received bytes in on the rx_byte channel, one item per byte; one byte
// can be taken every clock cycle. The unit looks for the header pair
// (header_first, header_second; FA AF after reset), then collects eight more
// bytes: six body bytes (id, command, two big-endian 16-bit words), the
// checksum (sum of the six body bytes modulo 256) and the tail. When the tail
// byte is processed one result item comes out with frame_status 0 for a good
// frame, 1 when the tail does not match tail_byte (checked first) and 2 when
// the checksum does not match; the data fields always carry what was received.
// All other bytes give no result. A byte passes an input register, the
// framing logic, and lands in the output register: a tail byte's result is
// written to the output register when the tail leaves the input register,
// and out_valid rises with it. Sustained rate is one byte per cycle; input
// stalls only when a tail byte meets a held, stalled result.
// Configuration writes (index 0 header_first, 1 header_second, 2 tail_byte;
// index 3 ignored) are always ready and should be made while the unit is idle.
// ============================================================================
module servo_frame_receiver_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    // byte input channel
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [sfr_pkg::BYTE_W-1:0]     rx_byte,
    // result channel
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [1:0]                     frame_status,
    output logic [sfr_pkg::BYTE_W-1:0]     servo_id,
    output logic [sfr_pkg::BYTE_W-1:0]     command,
    output logic [sfr_pkg::WORD_W-1:0]     word_first,
    output logic [sfr_pkg::WORD_W-1:0]     word_second,
    // configuration write channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [sfr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sfr_pkg::BYTE_W-1:0]     cfg_data
);
    import sfr_pkg::*;

    cfg_t    cfg;
    result_t result;
    logic    frame_done;

    // input register
    logic    in_valid_reg;
    byte_t   in_byte_reg;
    // output register
    logic    out_valid_reg;
    result_t out_reg;

    logic    advance;
    logic    step;

    sfr_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sfr_deframer u_deframer (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .rx_byte    (in_byte_reg),
        .cfg        (cfg),
        .frame_done (frame_done),
        .result     (result)
    );

    // The held byte moves on unless it is a tail whose result has nowhere
    // to go: output register full and the consumer stalling.
    assign advance  = !(frame_done && out_valid_reg && out_stall);
    assign step     = in_valid_reg && advance;
    assign in_stall = in_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_valid && !in_stall)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (step)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            in_byte_reg <= rx_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step && frame_done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && frame_done)
            out_reg <= result;
    end

    assign out_valid    = out_valid_reg;
    assign frame_status = out_reg.frame_status;
    assign servo_id     = out_reg.servo_id;
    assign command      = out_reg.command;
    assign word_first   = out_reg.word_first;
    assign word_second  = out_reg.word_second;

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top - bench for the servo frame receiver
// Drives serial bytes through the receiver with random bursts and output
// stalls, predicts every frame report in step and compares it field by
// field. A short byte table exercises header hunting and the frame checks.
// Random frame traffic follows under several register settings.
// ============================================================================
module tb_top;

    import sfr_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 6;
    localparam int DRAIN_CYCLES = 8;    // slack for bytes still in flight
    localparam int RAND_BYTES   = 1950;
    localparam int N_SETTINGS   = 8;
    localparam int DIR_ROWS     = 34;

    // Index 3 has no register behind it; writes there must be dropped.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    localparam result_t NO_RES = '0;

    // One row of the directed table: a byte, plus a typed-in report when
    // the byte is a tail whose outcome is obvious.
    typedef struct packed {
        logic    known;
        byte_t   rx;
        result_t res;
    } dir_row_t;

    localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
        // repeated first header byte, header values inside the body,
        // all-ones and all-zero words, good checksum and tail
        '{1'b0, 8'hFA, NO_RES},
        '{1'b0, 8'hFA, NO_RES},
        '{1'b0, 8'hAF, NO_RES},
        '{1'b0, 8'hFA, NO_RES},
        '{1'b0, 8'hAF, NO_RES},
        '{1'b0, 8'hFF, NO_RES},
        '{1'b0, 8'hFF, NO_RES},
        '{1'b0, 8'h00, NO_RES},
        '{1'b0, 8'h00, NO_RES},
        '{1'b0, 8'hA7, NO_RES},
        '{1'b1, 8'hED, '{ST_GOOD, 8'hFA, 8'hAF, 16'hFFFF, 16'h0000}},
        // stray byte after the first header byte drops back to hunting,
        // then a zero body with a wrong checksum
        '{1'b0, 8'hFA, NO_RES},
        '{1'b0, 8'h12, NO_RES},
        '{1'b0, 8'hAF, NO_RES},
        '{1'b0, 8'hFA, NO_RES},
        '{1'b0, 8'hAF, NO_RES},
        '{1'b0, 8'h00, NO_RES},
        '{1'b0, 8'h00, NO_RES},
        '{1'b0, 8'h00, NO_RES},
        '{1'b0, 8'h00, NO_RES},
        '{1'b0, 8'h00, NO_RES},
        '{1'b0, 8'h00, NO_RES},
        '{1'b0, 8'h01, NO_RES},
        '{1'b1, 8'hED, '{ST_SUM_BAD, 8'h00, 8'h00, 16'h0000, 16'h0000}},
        // both checks fail: tail wins
        '{1'b0, 8'hFA, NO_RES},
        '{1'b0, 8'hAF, NO_RES},
        '{1'b0, 8'h01, NO_RES},
        '{1'b0, 8'h02, NO_RES},
        '{1'b0, 8'h03, NO_RES},
        '{1'b0, 8'h04, NO_RES},
        '{1'b0, 8'h05, NO_RES},
        '{1'b0, 8'h06, NO_RES},
        '{1'b0, 8'h00, NO_RES},
        '{1'b1, 8'h00, '{ST_TAIL_BAD, 8'h01, 8'h02, 16'h0304, 16'h0506}}
    };

    // ------------------------------------------------------------------
    // DUT signals, the driven ones known from time zero
    // ------------------------------------------------------------------
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    byte_t                 rx_byte   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [1:0]            frame_status;
    byte_t                 servo_id;
    byte_t                 command;
    word_t                 word_first;
    word_t                 word_second;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    byte_t                 cfg_data  = '0;

    // ------------------------------------------------------------------
    // Predictor state: register mirror and framing state
    // ------------------------------------------------------------------
    byte_t              hdr_first  = HEADER_FIRST_RST;
    byte_t              hdr_second = HEADER_SECOND_RST;
    byte_t              tail_val   = TAIL_BYTE_RST;
    phase_t             cur_ph     = PH_HUNT;
    logic [COUNT_W-1:0] body_cnt   = '0;
    byte_t              run_sum    = '0;
    byte_t              body_mem [BODY_KEPT];
    byte_t              chk_byte   = '0;

    result_t frame_q [$];       // frame reports still owed by the DUT
    int      err_cnt    = 0;
    int      bytes_sent = 0;
    int      burst_left = 0;

    // receiver stall pattern state
    int stall_left = 0;
    int stall_mode = 0;
    int stall_tick = 0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    servo_frame_receiver_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .frame_status (frame_status),
        .servo_id     (servo_id),
        .command      (command),
        .word_first   (word_first),
        .word_second  (word_second),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // ------------------------------------------------------------------
    // Framing predictor: advance one accepted byte, report a frame on
    // the tail byte.
    // ------------------------------------------------------------------
    task automatic frame_predict(input byte_t b, output bit got, output result_t r);
        got = 1'b0;
        r   = NO_RES;
        case (cur_ph)
            PH_SECOND:
            begin
                // second header match is tested first, so equal header
                // registers still open a frame
                if (b == hdr_second)
                begin
                    cur_ph   = PH_BODY;
                    body_cnt = '0;
                    run_sum  = '0;
                end
                else if (b == hdr_first)
                    cur_ph = PH_SECOND;
                else
                    cur_ph = PH_HUNT;   // dropped, not retested as a first byte
            end
            PH_BODY:
            begin
                if (body_cnt < BODY_KEPT)
                begin
                    body_mem[body_cnt] = b;
                    run_sum            = run_sum + b;
                    body_cnt           = body_cnt + 1'b1;
                end
                else if (body_cnt < LAST_BODY)
                begin
                    chk_byte = b;
                    body_cnt = body_cnt + 1'b1;
                end
                else
                begin
                    // tail: tail check has priority over the sum check
                    if (b != tail_val)
                        r.frame_status = ST_TAIL_BAD;
                    else if (chk_byte != run_sum)
                        r.frame_status = ST_SUM_BAD;
                    else
                        r.frame_status = ST_GOOD;
                    r.servo_id    = body_mem[0];
                    r.command     = body_mem[1];
                    r.word_first  = {body_mem[2], body_mem[3]};
                    r.word_second = {body_mem[4], body_mem[5]};
                    got      = 1'b1;
                    cur_ph   = PH_HUNT;
                    body_cnt = '0;
                    run_sum  = '0;
                end
            end
            default:
                cur_ph = (b == hdr_first) ? PH_SECOND : PH_HUNT;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Byte sender: bursts of random length with random gaps. A typed-in
    // report, when given, replaces the predicted one.
    // ------------------------------------------------------------------
    task automatic send_byte(input byte_t b, input bit known, input result_t known_res);
        int      gap;
        bit      got;
        result_t pred;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            // now and then a long stretch with no gaps at all
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        frame_predict(b, got, pred);
        if (known)
            frame_q.push_back(known_res);
        else if (got)
            frame_q.push_back(pred);
        bytes_sent++;
        burst_left--;
    endtask

    // Register write; the mirror follows on acceptance.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input byte_t val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_HEADER_FIRST:  hdr_first  = val;
            REG_HEADER_SECOND: hdr_second = val;
            REG_TAIL_BYTE:     tail_val   = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Stop sending and wait until every owed report is out, plus pipeline
    // slack for bytes still in flight that give no report.
    task automatic drain_frames();
        @(negedge clk);
        in_valid <= 1'b0;
        burst_left = 0;
        while (frame_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic apply_setting(input byte_t h1, input byte_t h2, input byte_t t);
        drain_frames();
        write_reg(REG_HEADER_FIRST, h1);
        write_reg(REG_HEADER_SECOND, h2);
        write_reg(REG_TAIL_BYTE, t);
        write_reg(REG_UNUSED, byte_t'($urandom));
    endtask

    // ------------------------------------------------------------------
    // Random traffic: mostly well-formed frames with random content,
    // some truncated frames and loose noise.
    // ------------------------------------------------------------------
    task automatic frame_traffic(input int n_bytes);
        int    first;
        int    kind;
        int    n;
        int    i;
        byte_t fb [10];
        byte_t sum;
        first = bytes_sent;
        while (bytes_sent - first < n_bytes)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 7)
            begin
                // optional lead-in: noise or extra first header bytes
                n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
                for (i = 0; i < n; i++)
                    send_byte($urandom_range(0, 1) ? hdr_first : byte_t'($urandom),
                              1'b0, NO_RES);
                fb[0] = hdr_first;
                fb[1] = hdr_second;
                sum   = '0;
                for (i = 2; i < 8; i++)
                begin
                    case ($urandom_range(0, 11))
                        0:       fb[i] = hdr_first;
                        1:       fb[i] = hdr_second;
                        2:       fb[i] = tail_val;
                        default: fb[i] = byte_t'($urandom);
                    endcase
                    sum = sum + fb[i];
                end
                fb[8] = ($urandom_range(0, 4) == 0) ? byte_t'($urandom) : sum;
                fb[9] = ($urandom_range(0, 4) == 0) ? byte_t'($urandom) : tail_val;
                for (i = 0; i < 10; i++)
                    send_byte(fb[i], 1'b0, NO_RES);
            end
            else if (kind < 9)
            begin
                // header then a short body: the next frame lands in it
                send_byte(hdr_first, 1'b0, NO_RES);
                send_byte(hdr_second, 1'b0, NO_RES);
                n = $urandom_range(0, 7);
                for (i = 0; i < n; i++)
                    send_byte(byte_t'($urandom), 1'b0, NO_RES);
            end
            else
            begin
                n = $urandom_range(1, 6);
                for (i = 0; i < n; i++)
                    send_byte(byte_t'($urandom), 1'b0, NO_RES);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver stall: modes of random length - open, sparse random,
    // heavy stall, periodic.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 150);
        end
        stall_left--;
        stall_tick++;
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 2) == 0);
            2:       out_stall <= ($urandom_range(0, 9) != 0);
            default: out_stall <= stall_tick[2];
        endcase
    end

    // ------------------------------------------------------------------
    // Report checker: every accepted item against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (frame_q.size() == 0)
            begin
                $error("unexpected result item: status %0d id %0h", frame_status, servo_id);
                err_cnt++;
            end
            else
            begin
                want = frame_q.pop_front();
                if (frame_status !== want.frame_status)
                begin
                    $error("frame_status: expected %0d, actual %0d",
                           want.frame_status, frame_status);
                    err_cnt++;
                end
                if (servo_id !== want.servo_id)
                begin
                    $error("servo_id: expected %0h, actual %0h", want.servo_id, servo_id);
                    err_cnt++;
                end
                if (command !== want.command)
                begin
                    $error("command: expected %0h, actual %0h", want.command, command);
                    err_cnt++;
                end
                if (word_first !== want.word_first)
                begin
                    $error("word_first: expected %0h, actual %0h", want.word_first, word_first);
                    err_cnt++;
                end
                if (word_second !== want.word_second)
                begin
                    $error("word_second: expected %0h, actual %0h",
                           want.word_second, word_second);
                    err_cnt++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int    p;
        int    row;
        byte_t same_hdr;
        for (row = 0; row < BODY_KEPT; row++)
            body_mem[row] = '0;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed table under reset register values
        for (row = 0; row < DIR_ROWS; row++)
            send_byte(DIR_TAB[row].rx, DIR_TAB[row].known, DIR_TAB[row].res);

        // random traffic under a sequence of register settings
        for (p = 0; p < N_SETTINGS; p++)
        begin
            case (p)
                0: ;    // keep reset values
                1: apply_setting(8'h00, 8'h00, 8'h00);
                2: apply_setting(8'hFF, 8'hFF, 8'hFF);
                3:
                begin
                    // equal header registers
                    same_hdr = byte_t'($urandom);
                    apply_setting(same_hdr, same_hdr, byte_t'($urandom));
                end
                5: apply_setting(HEADER_FIRST_RST, HEADER_SECOND_RST, TAIL_BYTE_RST);
                default: apply_setting(byte_t'($urandom), byte_t'($urandom),
                                       byte_t'($urandom));
            endcase
            frame_traffic(RAND_BYTES / N_SETTINGS);
        end

        drain_frames();
        if (err_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: servo_frame_receiver_unit.f
hw/rtl/sfr_pkg.sv
hw/rtl/sfr_cfg_regs.sv
hw/rtl/sfr_deframer.sv
hw/rtl/servo_frame_receiver_unit.sv
bench/tb_top.sv
